>>> design/xavier_uniform_weight_scaler_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Xavier weight scaler
// Shorthand for clocked implication checks with a reset disable.
// ---------------------------------------------------------------------------
`ifndef XAVIER_UNIFORM_WEIGHT_SCALER_CORE_ASSERT_SVH
`define XAVIER_UNIFORM_WEIGHT_SCALER_CORE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds on the same edge.
`define XUS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xus check failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define XUS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xus check failed: next-cycle implication");

`endif

>>> design/xus_pkg.sv
// ---------------------------------------------------------------------------
// Xavier weight scaler package
// Shared constants and the controller-to-datapath command type.
// ---------------------------------------------------------------------------
package xus_pkg;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAN_IN  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAN_OUT = 2'd1;

   // Ratio numerator is 6 << 16, which needs 19 bits.
   localparam int RATIO_WIDTH = 19;
   localparam logic [RATIO_WIDTH-1:0] RATIO_NUM = 19'd393216;

   // Square root working width and the starting one-hot bit (largest even power).
   localparam int ROOT_WIDTH = 20;
   localparam logic [ROOT_WIDTH-1:0] ROOT_BIT_INIT = 20'h40000;

   // Iteration counts of the shared divide and root loops.
   localparam int STEP_WIDTH = 5;
   localparam logic [STEP_WIDTH-1:0] DIV_STEPS  = 5'd19;
   localparam logic [STEP_WIDTH-1:0] SQRT_STEPS = 5'd10;

   // Field widths and limits.
   localparam int SAMPLE_WIDTH = 16;
   localparam int LIMIT_WIDTH  = 8;
   localparam int WEIGHT_WIDTH = 8;
   localparam int PROD_WIDTH   = SAMPLE_WIDTH + LIMIT_WIDTH + 1;
   localparam int PROD_SHIFT   = 15;
   localparam int SHIFT_WIDTH  = PROD_WIDTH - PROD_SHIFT;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_MAX = 8'd255;
   localparam logic signed [SHIFT_WIDTH-1:0] WEIGHT_HI = 10'sd127;
   localparam logic signed [SHIFT_WIDTH-1:0] WEIGHT_LO = -10'sd128;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the sample and start the divide
      logic div_step;    // one restoring divide step
      logic sqrt_step;   // one restoring square root step
      logic sqrt_first;  // first root step takes the quotient as radicand
      logic limit_load;  // clamp the root into the limit register
      logic mul;         // register sample times limit
      logic out_load;    // load the result word registers
   } xus_cmd_type;

endpackage

>>> design/xavier_uniform_weight_scaler_core.sv
// ---------------------------------------------------------------------------
// Xavier uniform weight scaler core
// Scales a signed 16-bit random sample by the Xavier limit of a layer.
// ---------------------------------------------------------------------------
// Usage:
//   Set fan_in (index 0) and fan_out (index 1) through the csr_ write port
//   while the core is idle; both reset to 1 and bits above FAN_WIDTH are
//   dropped. Each word on the req_ channel gives one word on the rsp_
//   channel: the weight floor((sample * limit) / 2^15) saturated to int8,
//   and the limit itself, min(isqrt((6 << 16) / (fan_in + fan_out)), 255).
//   After a request is accepted, the word passes in order through the
//   restoring divider, the restoring square root, the clamp of the limit,
//   the multiplier and the load of the output register. One word is in
//   flight at a time, set by the shared divide and root loops: the core
//   accepts the next word only once it has loaded the output register and
//   returned to idle.
//   The output register lets the core finish a word while the previous
//   result waits; if the receiver still stalls, the core holds in its final
//   step and req_ready stays low. Reset empties the output and returns the
//   controller to idle. There is no clearing pass.
// ---------------------------------------------------------------------------
module xavier_uniform_weight_scaler_core #(
   parameter int FAN_WIDTH = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_enable,
   input  logic [xus_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [FAN_WIDTH-1:0]                     csr_write_data,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [xus_pkg::SAMPLE_WIDTH-1:0]  req_random_sample,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [xus_pkg::WEIGHT_WIDTH-1:0]  rsp_weight,
   output logic [xus_pkg::LIMIT_WIDTH-1:0]          rsp_bound_limit
);
   import xus_pkg::*;

   xus_cmd_type cmd;

   // Sequencer.
   xus_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Arithmetic and configuration registers.
   xus_dpath #(
      .FAN_WIDTH (FAN_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_random_sample (req_random_sample),
      .cmd               (cmd),
      .rsp_weight        (rsp_weight),
      .rsp_bound_limit   (rsp_bound_limit)
   );

endmodule

>>> design/xus_ctrl.sv
// ---------------------------------------------------------------------------
// Xavier weight scaler controller
// Sequences divide, root, multiply and output steps for one word at a time.
// ---------------------------------------------------------------------------
module xus_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output xus_pkg::xus_cmd_type cmd
);
   import xus_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_SQRT = 3'd2;
   localparam logic [2:0] ST_LIM  = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic                  valid_ff, valid_in;
   logic                  slot_free;

   // The output register can take a word when empty or being drained.
   assign slot_free = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

   // Next state, step count and commands.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == DIV_STEPS - 5'd1) begin
               step_in  = '0;
               state_in = ST_SQRT;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step  = 1'b1;
            cmd.sqrt_first = (step_ff == '0);
            if (step_ff == SQRT_STEPS - 5'd1) begin
               step_in  = '0;
               state_in = ST_LIM;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         ST_LIM: begin
            cmd.limit_load = 1'b1;
            state_in       = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid flag: set on load, cleared when the word is taken.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

endmodule

>>> design/xus_dpath.sv
// ---------------------------------------------------------------------------
// Xavier weight scaler datapath
// Fan registers, restoring divider, restoring square root, multiplier and
// saturating output registers, each stepped by controller commands.
// ---------------------------------------------------------------------------
module xus_dpath #(
   parameter int FAN_WIDTH = 8
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_write_enable,
   input  logic [xus_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [FAN_WIDTH-1:0]                       csr_write_data,
   input  logic signed [xus_pkg::SAMPLE_WIDTH-1:0]    req_random_sample,
   input  xus_pkg::xus_cmd_type                       cmd,
   output logic signed [xus_pkg::WEIGHT_WIDTH-1:0]    rsp_weight,
   output logic [xus_pkg::LIMIT_WIDTH-1:0]            rsp_bound_limit
);
   import xus_pkg::*;

   localparam int SUM_WIDTH = FAN_WIDTH + 1;

   logic [FAN_WIDTH-1:0]             fan_in_ff, fan_out_ff;
   logic [SUM_WIDTH-1:0]             fan_sum;
   logic signed [SAMPLE_WIDTH-1:0]   sample_ff;

   logic [RATIO_WIDTH-1:0]           quo_ff, quo_in;
   logic [SUM_WIDTH-1:0]             rem_ff, rem_in;
   logic [SUM_WIDTH:0]               div_trial, div_diff;
   logic                             div_take;

   logic [RATIO_WIDTH-1:0]           rad_ff, rad_in, rad_cur;
   logic [ROOT_WIDTH-1:0]            res_ff, res_in, bit_ff, bit_in, root_trial;
   logic                             root_take;

   logic [LIMIT_WIDTH-1:0]           limit_ff;
   logic signed [PROD_WIDTH-1:0]     prod_ff;
   logic signed [SHIFT_WIDTH-1:0]    shifted;
   logic signed [WEIGHT_WIDTH-1:0]   weight_ff, weight_in;
   logic [LIMIT_WIDTH-1:0]           bound_ff;

   // Configuration registers; writes to other indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         fan_in_ff  <= FAN_WIDTH'(1);
         fan_out_ff <= FAN_WIDTH'(1);
      end else if (csr_write_enable) begin
         if (csr_index == CSR_FAN_IN) begin
            fan_in_ff <= csr_write_data;
         end
         if (csr_index == CSR_FAN_OUT) begin
            fan_out_ff <= csr_write_data;
         end
      end
   end

   assign fan_sum = {1'b0, fan_in_ff} + {1'b0, fan_out_ff};

   // Restoring divide step: shift in the next numerator bit and try a subtract.
   // A zero divisor always subtracts, so the quotient comes out all ones.
   always_comb begin
      div_trial = {rem_ff, quo_ff[RATIO_WIDTH-1]};
      div_take  = (div_trial >= {1'b0, fan_sum});
      div_diff  = div_trial - {1'b0, fan_sum};
      rem_in    = div_take ? div_diff[SUM_WIDTH-1:0] : div_trial[SUM_WIDTH-1:0];
      quo_in    = {quo_ff[RATIO_WIDTH-2:0], div_take};
   end

   // Restoring square root step on the quotient.
   always_comb begin
      rad_cur    = cmd.sqrt_first ? quo_ff : rad_ff;
      root_trial = res_ff + bit_ff;
      root_take  = ({1'b0, rad_cur} >= root_trial);
      if (root_take) begin
         rad_in = rad_cur - root_trial[RATIO_WIDTH-1:0];
         res_in = (res_ff >> 1) + bit_ff;
      end else begin
         rad_in = rad_cur;
         res_in = res_ff >> 1;
      end
      bit_in = bit_ff >> 2;
   end

   // Floor shift of the product, then saturation to the int8 range.
   always_comb begin
      shifted = prod_ff[PROD_WIDTH-1:PROD_SHIFT];
      if (shifted > WEIGHT_HI) begin
         weight_in = WEIGHT_HI[WEIGHT_WIDTH-1:0];
      end else if (shifted < WEIGHT_LO) begin
         weight_in = WEIGHT_LO[WEIGHT_WIDTH-1:0];
      end else begin
         weight_in = shifted[WEIGHT_WIDTH-1:0];
      end
   end

   // Working registers, advanced one command at a time.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_random_sample;
         quo_ff    <= RATIO_NUM;
         rem_ff    <= '0;
         res_ff    <= '0;
         bit_ff    <= ROOT_BIT_INIT;
      end
      if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.sqrt_step) begin
         rad_ff <= rad_in;
         res_ff <= res_in;
         bit_ff <= bit_in;
      end
      if (cmd.limit_load) begin
         limit_ff <= (res_ff > ROOT_WIDTH'(LIMIT_MAX)) ? LIMIT_MAX
                                                       : res_ff[LIMIT_WIDTH-1:0];
      end
      if (cmd.mul) begin
         prod_ff <= sample_ff * $signed({1'b0, limit_ff});
      end
      if (cmd.out_load) begin
         weight_ff <= weight_in;
         bound_ff  <= limit_ff;
      end
   end

   assign rsp_weight      = weight_ff;
   assign rsp_bound_limit = bound_ff;

endmodule

>>> design/xus_checker.sv
// ---------------------------------------------------------------------------
// Xavier weight scaler port checker
// Watches the top-level ports for handshake and result consistency.
// ---------------------------------------------------------------------------
`include "xavier_uniform_weight_scaler_core_assert.svh"

module xus_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_valid,
   input logic                                     req_ready,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic signed [xus_pkg::WEIGHT_WIDTH-1:0]  rsp_weight,
   input logic [xus_pkg::LIMIT_WIDTH-1:0]          rsp_bound_limit
);

   // A stalled result word stays offered.
   `XUS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A stalled result word keeps its payload.
   `XUS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_weight) && $stable(rsp_bound_limit))

   // Only one word is worked on at a time: the core is busy right after accepting.
   `XUS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // The ratio is at least 771 with 8-bit fans, so the limit is never zero.
   `XUS_ASSERT_SAME(a_limit_nonzero, clock, reset, rsp_valid, rsp_bound_limit != '0)

endmodule

bind xavier_uniform_weight_scaler_core xus_checker u_xus_checker (.*);

>>> tb/sv/xavier_uniform_weight_scaler_core_test.sv
// ---------------------------------------------------------------------------
// Xavier uniform weight scaler core testbench
// Sends random samples under several fan settings and checks each result word
// against a local model of the clamped square-root limit and saturated weight.
// ---------------------------------------------------------------------------
module xavier_uniform_weight_scaler_core_test;

   localparam int FAN_WIDTH     = 8;
   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 10;
   localparam int DRAIN_CYCLES  = 40;
   localparam int IDLE_PERCENT  = 37;
   localparam int HOLD_OFF_LONG = 200;
   localparam int PHASE_WORDS   = 60;

   // Register indexes past the end of the register list.
   localparam logic [xus_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [xus_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = 2'd3;

   typedef logic signed [xus_pkg::SAMPLE_WIDTH-1:0] sample_t;
   typedef logic [FAN_WIDTH-1:0] fan_t;

   typedef struct packed {
      logic signed [xus_pkg::WEIGHT_WIDTH-1:0] weight;
      logic [xus_pkg::LIMIT_WIDTH-1:0]         bound_limit;
   } scaled_word_t;

   localparam sample_t SAMPLE_MAX = 16'sh7FFF;
   localparam sample_t SAMPLE_MIN = 16'sh8000;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    csr_write_enable = 1'b0;
   logic [xus_pkg::CSR_INDEX_WIDTH-1:0]     csr_index = '0;
   fan_t                                    csr_write_data = '0;
   logic                                    req_valid = 1'b0;
   logic                                    req_ready;
   sample_t                                 req_random_sample = '0;
   logic                                    rsp_valid;
   logic                                    rsp_ready = 1'b0;
   logic signed [xus_pkg::WEIGHT_WIDTH-1:0] rsp_weight;
   logic [xus_pkg::LIMIT_WIDTH-1:0]         rsp_bound_limit;

   // Model copy of the fan registers and the words still owed by the core.
   fan_t         fan_in_setting  = 1;
   fan_t         fan_out_setting = 1;
   scaled_word_t expected_words[$];
   int           error_count     = 0;
   int           hold_off_cycles = 0;
   bit           sender_idles    = 1'b1;
   bit           receiver_idles  = 1'b1;

   xavier_uniform_weight_scaler_core #(
      .FAN_WIDTH(FAN_WIDTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_random_sample(req_random_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_weight       (rsp_weight),
      .rsp_bound_limit  (rsp_bound_limit)
   );

   always #CLOCK_HALF clock = ~clock;

   // Weight and limit for one sample under the current fan settings.
   function automatic scaled_word_t scale_sample(input sample_t sample);
      logic [FAN_WIDTH:0] fan_sum;
      logic [31:0]        ratio;
      int                 bound;
      int                 product;
      int                 shifted;
      scaled_word_t       word;
      fan_sum = {1'b0, fan_in_setting} + {1'b0, fan_out_setting};
      // A zero divisor makes the divider answer all ones.
      if (fan_sum == 0) begin
         ratio = 32'hFFFF_FFFF;
      end else begin
         ratio = 32'(xus_pkg::RATIO_NUM) / 32'(fan_sum);
      end
      // Largest root not above the clamp whose square fits in the ratio.
      bound = 0;
      for (int r = 1; r <= int'(xus_pkg::LIMIT_MAX); r++) begin
         if (64'(r) * 64'(r) <= 64'(ratio)) begin
            bound = r;
         end
      end
      product = int'(sample) * bound;
      shifted = product >>> xus_pkg::PROD_SHIFT;
      if (shifted > int'(xus_pkg::WEIGHT_HI)) begin
         shifted = int'(xus_pkg::WEIGHT_HI);
      end else if (shifted < int'(xus_pkg::WEIGHT_LO)) begin
         shifted = int'(xus_pkg::WEIGHT_LO);
      end
      word.weight      = shifted[xus_pkg::WEIGHT_WIDTH-1:0];
      word.bound_limit = bound[xus_pkg::LIMIT_WIDTH-1:0];
      return word;
   endfunction

   // Mostly uniform samples, with the edge values now and then.
   function automatic sample_t pick_sample();
      case ($urandom_range(9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return sample_t'($urandom_range(2)) - 1;
         default: return sample_t'($urandom_range(16'hFFFF));
      endcase
   endfunction

   // Offer one sample word and record its expected result once taken.
   task automatic send_sample(input sample_t sample);
      while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_random_sample <= sample;
      do @(posedge clock); while (!req_ready);
      expected_words.push_back(scale_sample(sample));
   endtask

   // Stop offering and wait until every owed word has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   task automatic write_register(input logic [xus_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input fan_t value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == xus_pkg::CSR_FAN_IN) begin
         fan_in_setting = value;
      end else if (index == xus_pkg::CSR_FAN_OUT) begin
         fan_out_setting = value;
      end
      @(posedge clock);
   endtask

   task automatic configure(input fan_t fan_in_value, input fan_t fan_out_value);
      wait_idle();
      write_register(xus_pkg::CSR_FAN_IN, fan_in_value);
      write_register(xus_pkg::CSR_FAN_OUT, fan_out_value);
   endtask

   // Reset values of both fans give a limit far above the clamp.
   task automatic test_reset_defaults();
      send_sample(16'sd0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(-16'sd1);
   endtask

   // Both fans zero, both at their maximum, and one side zero.
   task automatic test_fan_extremes();
      configure(0, 0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      configure(255, 255);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(16'sd1);
      send_sample(-16'sd1);
      configure(255, 0);
      send_sample(16'sh5555);
      configure(0, 255);
      send_sample(-16'sh2AAB);
   endtask

   // Limits just at and just below the clamp push the weight past int8.
   task automatic test_saturation();
      configure(3, 3);
      send_sample(SAMPLE_MAX);
      configure(3, 4);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(16'sh4000);
   endtask

   // Writes past the register list must leave both fans alone.
   task automatic test_spare_index();
      configure(0, 0);
      write_register(CSR_SPARE_LOW, 8'hA5);
      write_register(CSR_SPARE_HIGH, 8'h5A);
      send_sample(16'sh1234);
      send_sample(-16'sh1234);
   endtask

   // Random fans over several phases, one of them with no idling at all.
   task automatic test_random_settings();
      for (int phase = 0; phase < 6; phase++) begin
         if (phase % 3 == 0) begin
            configure(fan_t'($urandom_range(6)), fan_t'($urandom_range(6)));
         end else begin
            configure(fan_t'($urandom_range(255)), fan_t'($urandom_range(255)));
         end
         sender_idles   = (phase != 2);
         receiver_idles = (phase != 2);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            send_sample(pick_sample());
         end
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // The receiver holds off long enough for the core to stall its input.
   task automatic test_back_pressure();
      configure(fan_t'($urandom_range(12)), fan_t'($urandom_range(255)));
      sender_idles    = 1'b0;
      hold_off_cycles = HOLD_OFF_LONG;
      for (int n = 0; n < 12; n++) begin
         send_sample(pick_sample());
      end
      sender_idles = 1'b1;
      for (int n = 0; n < 8; n++) begin
         send_sample(pick_sample());
      end
   endtask

   // Result side: check each accepted word, then pick the next ready.
   initial begin : result_side
      scaled_word_t wanted;
      logic         ready_next;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word: weight %0d, bound_limit %0d",
                      rsp_weight, rsp_bound_limit);
               error_count++;
            end else begin
               wanted = expected_words.pop_front();
               if (rsp_weight !== wanted.weight) begin
                  $error("weight: expected %0d, actual %0d", wanted.weight, rsp_weight);
                  error_count++;
               end
               if (rsp_bound_limit !== wanted.bound_limit) begin
                  $error("bound_limit: expected %0d, actual %0d",
                         wanted.bound_limit, rsp_bound_limit);
                  error_count++;
               end
            end
         end
         if (hold_off_cycles > 0) begin
            ready_next = 1'b0;
            hold_off_cycles--;
         end else begin
            ready_next = !(receiver_idles && $urandom_range(99) < IDLE_PERCENT);
         end
         rsp_ready <= ready_next;
      end
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #5_000_000;
      $display("FAIL xavier_uniform_weight_scaler_core");
      $finish;
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_fan_extremes();
      test_saturation();
      test_spare_index();
      test_random_settings();
      test_back_pressure();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS xavier_uniform_weight_scaler_core");
      end else begin
         $display("FAIL xavier_uniform_weight_scaler_core");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/xus_pkg.sv
design/xus_ctrl.sv
design/xus_dpath.sv
design/xavier_uniform_weight_scaler_core.sv
design/xus_checker.sv
tb/sv/xavier_uniform_weight_scaler_core_test.sv
